// ----- rtl/core/xor_linear_basis_macros.svh -----
// Assertion macros shared by the XOR linear basis RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef XOR_LINEAR_BASIS_MACROS_SVH
`define XOR_LINEAR_BASIS_MACROS_SVH

// Checks that the consequent holds whenever the antecedent holds, outside reset.
`define XLB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xor linear basis check failed");

// Checks that a condition holds at every clock edge outside reset.
`define XLB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	`XLB_ASSERT_IMPLIES(lbl, clk, rst_n, 1'b1, cond)

`endif

// ----- rtl/core/xlb_pkg.sv -----
// Package for the XOR linear basis: sizes, operation codes, payload structs and state types.
// Used by every module of the block but xlb_ram; depends on nothing.
package xlb_pkg;

	// Number of bits in a basis vector, and so the number of slots.
	localparam int BITS = 63;
	// Fixed width of the value and result fields.
	localparam int VAL_W = 63;
	localparam int VAL_IDX_W = $clog2(VAL_W);
	localparam int SLOT_W = $clog2(BITS);
	localparam int CNT_W = $clog2(BITS + 1);
	localparam logic [VAL_W-1:0] VEC_MASK = {VAL_W{1'b1}} >> (VAL_W - BITS);
	localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(BITS - 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CHECK  = 2'd1,
		OP_MAX    = 2'd2,
		OP_KTH    = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] result;
		logic             ok;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Running state of one walk over the slots.
	typedef struct packed {
		logic [VAL_W-1:0]  acc;    // vector being reduced, or the value being built
		logic              found;  // an empty slot was hit during reduction
		logic [SLOT_W-1:0] slot;   // that empty slot
		logic [CNT_W-1:0]  pos;    // filled slots still below, for the rank query
	} walk_t;

endpackage

// ----- rtl/core/xlb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module xlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/xlb_slot_step.sv -----
// One step of the slot walk: folds one basis slot into the running walk state.
// Depends on xlb_pkg.
module xlb_slot_step (
	input  xlb_pkg::op_t                 op,
	input  logic [xlb_pkg::SLOT_W-1:0]   slot,
	input  logic [xlb_pkg::VAL_W-1:0]    slot_vec,
	input  logic                         slot_vld,
	input  logic [xlb_pkg::VAL_W-1:0]    rank_idx,
	input  xlb_pkg::walk_t               cur,
	output xlb_pkg::walk_t               nxt
);

	logic [xlb_pkg::VAL_IDX_W-1:0] bit_idx;
	logic [xlb_pkg::CNT_W-1:0]     pos_dec;
	logic                          acc_bit;
	logic                          sel;

	// A filled slot's vector has its top set bit at the slot index, so the
	// ordering tests of the greedy walks reduce to single bit tests.
	always_comb begin
		bit_idx = xlb_pkg::VAL_IDX_W'(slot);
		acc_bit = cur.acc[bit_idx];
		pos_dec = cur.pos - xlb_pkg::CNT_W'(1);
		sel     = rank_idx[xlb_pkg::VAL_IDX_W'(pos_dec)];
		nxt     = cur;
		unique case (op)
			xlb_pkg::OP_INSERT, xlb_pkg::OP_CHECK: begin
				if (!cur.found && acc_bit) begin
					if (slot_vld) begin
						nxt.acc = cur.acc ^ slot_vec;
					end else begin
						nxt.found = 1'b1;
						nxt.slot  = slot;
					end
				end
			end
			xlb_pkg::OP_MAX: begin
				if (slot_vld && !acc_bit) begin
					nxt.acc = cur.acc ^ slot_vec;
				end
			end
			xlb_pkg::OP_KTH: begin
				if (slot_vld) begin
					nxt.pos = pos_dec;
					if (acc_bit != sel) begin
						nxt.acc = cur.acc ^ slot_vec;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ----- rtl/core/xor_linear_basis.sv -----
// Top level of the XOR linear basis over GF(2): control, slot memory and result register.
// Depends on xlb_pkg, xlb_ram, xlb_slot_step and xor_linear_basis_macros.svh.
//
//   channel | direction | valid      | stall      | payload
//   --------+-----------+------------+------------+---------------------------
//   cmd     | in        | cmd_valid  | cmd_stall  | cmd (op, value)
//   res     | out       | res_valid  | res_stall  | res (result, ok)
//
// Every operation walks all BITS slots from the top slot down, one per cycle through
// the memory's read port; the result is registered when the walk commits, and the
// next command can transfer in the cycle after the result at the earliest.
// Reset clears the per-slot valid flags, the count and the zero flag at once;
// there is no clearing pass over the memory. A stalled result waits in the
// output register; a finished walk waits for it to drain before it commits.
module xor_linear_basis (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  xlb_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output xlb_pkg::res_t res
);

	`include "xor_linear_basis_macros.svh"

	// Control state.
	xlb_pkg::state_t state_q;
	xlb_pkg::state_t state_d;
	logic [xlb_pkg::BITS-1:0]   slot_vld_q;
	logic [xlb_pkg::CNT_W-1:0]  count_q;
	logic                       zero_reach_q;
	logic [xlb_pkg::SLOT_W-1:0] cnt_q;
	logic                       res_valid_q;

	// Per-item working registers.
	xlb_pkg::op_t               op_q;
	xlb_pkg::walk_t             walk_q;
	xlb_pkg::walk_t             walk_nxt;
	logic [xlb_pkg::VAL_W-1:0]  idx_q;
	logic                       kzero_q;
	xlb_pkg::res_t              res_q;

	// Memory ports.
	logic                       ram_we;
	logic [xlb_pkg::SLOT_W-1:0] ram_raddr;
	logic [xlb_pkg::BITS-1:0]   ram_rdata;
	logic [xlb_pkg::VAL_W-1:0]  slot_vec;

	logic                       cmd_xfer;
	logic                       res_free;
	logic                       commit;
	logic                       rank_over;
	xlb_pkg::res_t              res_d;

	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign res_free = !res_valid_q || !res_stall;
	assign commit   = (state_q == xlb_pkg::ST_FINISH) && res_free;

	// The slot memory. An entry that was never written is masked by its valid
	// flag. Writes happen only when a walk commits, and the next walk issues its
	// first read no earlier than the following cycle, so a read never races a
	// write to the same entry.
	xlb_ram #(
		.WIDTH (xlb_pkg::BITS),
		.DEPTH (xlb_pkg::BITS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (walk_q.slot),
		.wdata (walk_q.acc[xlb_pkg::BITS-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_vec = slot_vld_q[cnt_q] ? xlb_pkg::VAL_W'(ram_rdata) : '0;

	xlb_slot_step u_step (
		.op       (op_q),
		.slot     (cnt_q),
		.slot_vec (slot_vec),
		.slot_vld (slot_vld_q[cnt_q]),
		.rank_idx (idx_q),
		.cur      (walk_q),
		.nxt      (walk_nxt)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			xlb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = xlb_pkg::ST_WALK;
				end
			end
			xlb_pkg::ST_WALK: begin
				if (cnt_q == '0) begin
					state_d = xlb_pkg::ST_FINISH;
				end
			end
			xlb_pkg::ST_FINISH: begin
				if (res_free) begin
					state_d = xlb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = xlb_pkg::ST_IDLE;
			end
		endcase
	end

	// State-driven outputs: input stall, memory read address and write enable.
	always_comb begin
		cmd_stall = 1'b1;
		ram_raddr = xlb_pkg::TOP_SLOT;
		ram_we    = 1'b0;
		unique case (state_q)
			xlb_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
			end
			xlb_pkg::ST_WALK: begin
				// Prefetch the slot below the one whose data arrives now.
				ram_raddr = (cnt_q == '0) ? '0 : cnt_q - xlb_pkg::SLOT_W'(1);
			end
			xlb_pkg::ST_FINISH: begin
				ram_we = res_free && (op_q == xlb_pkg::OP_INSERT) && walk_q.found;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	// A rank is out of range when its zero-based index has a set bit at or
	// above the current count of filled slots.
	always_comb begin
		rank_over = 1'b0;
		for (int j = 0; j < xlb_pkg::VAL_W; j++) begin
			if (idx_q[j] && (j >= int'(count_q))) begin
				rank_over = 1'b1;
			end
		end
	end

	// Result of the finished walk.
	always_comb begin
		res_d.result = '0;
		res_d.ok     = 1'b0;
		unique case (op_q)
			xlb_pkg::OP_INSERT: begin
				res_d.ok = walk_q.found;
			end
			xlb_pkg::OP_CHECK: begin
				res_d.ok = !walk_q.found;
			end
			xlb_pkg::OP_MAX: begin
				res_d.result = walk_q.acc;
				res_d.ok     = 1'b1;
			end
			xlb_pkg::OP_KTH: begin
				res_d.ok     = !kzero_q && !rank_over;
				res_d.result = res_d.ok ? walk_q.acc : '0;
			end
			default: begin
				res_d.ok = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= xlb_pkg::ST_IDLE;
			slot_vld_q   <= '0;
			count_q      <= '0;
			zero_reach_q <= 1'b0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_xfer) begin
				cnt_q <= xlb_pkg::TOP_SLOT;
			end else if (state_q == xlb_pkg::ST_WALK && cnt_q != '0) begin
				cnt_q <= cnt_q - xlb_pkg::SLOT_W'(1);
			end
			if (commit && op_q == xlb_pkg::OP_INSERT) begin
				if (walk_q.found) begin
					slot_vld_q[walk_q.slot] <= 1'b1;
					count_q                 <= count_q + xlb_pkg::CNT_W'(1);
				end else begin
					zero_reach_q <= 1'b1;
				end
			end
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working and payload registers.
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q        <= cmd.op;
			kzero_q     <= (cmd.value == '0);
			idx_q       <= zero_reach_q ? cmd.value - xlb_pkg::VAL_W'(1) : cmd.value;
			walk_q.acc  <= (cmd.op == xlb_pkg::OP_INSERT || cmd.op == xlb_pkg::OP_CHECK)
				? (cmd.value & xlb_pkg::VEC_MASK) : '0;
			walk_q.found <= 1'b0;
			walk_q.slot  <= '0;
			walk_q.pos   <= count_q;
		end else if (state_q == xlb_pkg::ST_WALK) begin
			walk_q <= walk_nxt;
		end
		if (commit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The count of filled slots always matches the valid flags.
	`XLB_ASSERT_ALWAYS(a_count_matches, clk, arst_n, count_q == $countones(slot_vld_q))

	// An insert only ever commits into a slot that was empty.
	`XLB_ASSERT_IMPLIES(a_insert_empty_slot, clk, arst_n, ram_we, !slot_vld_q[walk_q.slot])

	// The rank walk never meets more filled slots than it counted at the start.
	`XLB_ASSERT_IMPLIES(a_rank_pos_nonzero, clk, arst_n,
		state_q == xlb_pkg::ST_WALK && op_q == xlb_pkg::OP_KTH && slot_vld_q[cnt_q],
		walk_q.pos != '0)

endmodule

// ----- tb/xor_linear_basis_checker.sv -----
// Checker for the XOR linear basis: watches both channels and predicts every result.
// Depends on xlb_pkg for the payload structs, the operation codes and the sizes.
module xor_linear_basis_checker
	import xlb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   failures
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted basis: one vector per leading bit, zero when the slot is empty.
	logic [VAL_W-1:0] slot_vec [BITS];
	logic             zero_hit;
	int unsigned      filled;

	res_t expected_q [$];
	res_t want;
	int   errs;

	// Applies one command to the predicted basis and returns the result it must produce.
	function automatic res_t apply_op(cmd_t c);
		res_t             r;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] alt;
		logic [63:0]      rank;
		logic [63:0]      idx;
		logic [63:0]      last;
		int               free_slot;
		int               pos;
		r = '0;
		case (c.op)
			OP_INSERT, OP_CHECK: begin
				v = c.value & VEC_MASK;
				free_slot = -1;
				for (int i = BITS - 1; i >= 0 && free_slot < 0; i--) begin
					if (v[i]) begin
						if (slot_vec[i] != '0)
							v ^= slot_vec[i];
						else
							free_slot = i;
					end
				end
				if (c.op == OP_CHECK) begin
					r.ok = (free_slot < 0);
				end else if (free_slot >= 0) begin
					slot_vec[free_slot] = v;
					filled++;
					r.ok = 1'b1;
				end else begin
					zero_hit = 1'b1;
				end
			end
			OP_MAX: begin
				x = '0;
				for (int i = BITS - 1; i >= 0; i--)
					if ((x ^ slot_vec[i]) > x)
						x ^= slot_vec[i];
				r.result = x;
				r.ok = 1'b1;
			end
			default: begin
				rank = {1'b0, c.value};
				idx = zero_hit ? rank - 64'd1 : rank;
				last = (64'd1 << filled) - 64'd1;
				if (rank != 64'd0 && idx <= last) begin
					// Each filled slot, from the top, picks the lower or the higher
					// of the two candidates by one bit of the zero-based rank.
					x = '0;
					pos = filled;
					for (int i = BITS - 1; i >= 0; i--) begin
						if (slot_vec[i] != '0) begin
							pos--;
							alt = x ^ slot_vec[i];
							if (idx[pos])
								x = (alt < x) ? x : alt;
							else
								x = (alt < x) ? alt : x;
						end
					end
					r.result = x;
					r.ok = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BITS; i++)
				slot_vec[i] = '0;
			zero_hit = 1'b0;
			filled = 0;
			expected_q.delete();
			errs = 0;
			failures <= 0;
		end else begin
			// The result side goes first: a result at this edge belongs to an older command.
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					errs++;
					$display("%0t: result %h ok %b arrived with nothing expected",
						$realtime, res.result, res.ok);
				end else begin
					want = expected_q.pop_front();
					if (res.result !== want.result) begin
						errs++;
						$display("%0t: result mismatch, expected %h, got %h",
							$realtime, want.result, res.result);
					end
					if (res.ok !== want.ok) begin
						errs++;
						$display("%0t: ok mismatch, expected %b, got %b",
							$realtime, want.ok, res.ok);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_q.push_back(apply_op(cmd));
			// Results still owed count as failures if the run ends here.
			failures <= errs + expected_q.size();
		end
	end

endmodule

// ----- tb/xor_linear_basis_test.sv -----
// Top of the XOR linear basis testbench: clock, reset, command stimulus and result stalls.
// Depends on xlb_pkg, the xor_linear_basis block and xor_linear_basis_checker.
module xor_linear_basis_test;
	timeunit 1ns;
	timeprecision 1ps;
	import xlb_pkg::*;

	localparam int N_RAND         = 500;
	localparam int LONG_HOLD      = 250;   // cycles the result side holds off once
	localparam int HOLD_AT        = 120;   // result count at which that hold-off starts
	localparam int QUIET_FIRST    = 300;   // window of items with no idling on either side
	localparam int QUIET_LAST     = 360;
	localparam int PAUSE_AT       = 200;   // random item before which the sender drains
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int POOL_MAX       = 64;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int failures;
	int sent = 0;
	int received = 0;
	int idle_cycles = 0;

	// Vectors already inserted; XORs of them give dependent inserts and
	// representable membership checks.
	logic [VAL_W-1:0] pool [$];
	cmd_t directed [$];

	xor_linear_basis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	xor_linear_basis_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.failures  (failures)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Transfer counters for the sender's drain, and a watchdog that ends the run
	// when neither channel has moved a transfer for too long.
	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			sent <= sent + 1;
		if (res_valid && !res_stall)
			received <= received + 1;
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("xor_linear_basis_test: done, errors");
			$finish;
		end
	end

	function automatic cmd_t mk(op_t o, logic [VAL_W-1:0] v);
		cmd_t c;
		c.op = o;
		c.value = v;
		return c;
	endfunction

	function automatic logic [VAL_W-1:0] pool_mix();
		logic [VAL_W-1:0] acc;
		int               picks;
		acc = '0;
		picks = $urandom_range(1, 4);
		for (int j = 0; j < picks; j++)
			acc ^= pool[$urandom_range(0, pool.size() - 1)];
		return acc;
	endfunction

	// Random commands. Vectors start narrow and widen over the run, so the basis
	// fills slowly and dependent inserts, failed checks and ranks near the edge of
	// the reachable set keep turning up instead of the basis saturating at once.
	function automatic cmd_t next_random(int n);
		cmd_t             c;
		logic [63:0]      raw;
		logic [VAL_W-1:0] v;
		int               w;
		int               e;
		int               pick;
		w = 3 + (n * 60) / N_RAND;
		if (w > VAL_W)
			w = VAL_W;
		raw = {$urandom, $urandom};
		v = raw[VAL_W-1:0];
		// An occasional full-width vector keeps the high bits moving.
		if ($urandom_range(0, 15) != 0)
			v &= (VAL_W'(1) << w) - VAL_W'(1);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			c.op = OP_INSERT;
			if ($urandom_range(0, 4) == 0 && pool.size() > 0)
				v = pool_mix();
			pool.push_back(v);
			if (pool.size() > POOL_MAX)
				void'(pool.pop_front());
		end else if (pick < 60) begin
			c.op = OP_CHECK;
			if ($urandom_range(0, 9) < 6 && pool.size() > 0)
				v = pool_mix();
		end else if (pick < 75) begin
			c.op = OP_MAX;
		end else begin
			// Ranks cluster around powers of two, where the reachable count lies.
			c.op = OP_KTH;
			e = $urandom_range(0, (w < VAL_W - 1) ? w : VAL_W - 1);
			v = VAL_W'(1) << e;
			case ($urandom_range(0, 5))
				0: v = v - VAL_W'(1);
				1: v = v + VAL_W'(1);
				2: v = '0;
				3: v = raw[VAL_W-1:0];
				4: v = VAL_W'($urandom_range(1, 40));
				default: ;
			endcase
		end
		c.value = v;
		return c;
	endfunction

	// Offers one command after a random gap, or none when hurried, and holds it until the block takes it.
	task automatic send_item(cmd_t c, bit hurry);
		int gap;
		gap = hurry ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Stops offering and waits until every command sent has produced its result.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (received != sent)
			@(posedge clk);
	endtask

	// Result side: a random stall before every result, one long hold-off that
	// lets the block back up into its command channel, and a window with none.
	initial begin
		int w;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				w = LONG_HOLD;
			else if (taken >= QUIET_FIRST && taken < QUIET_LAST)
				w = 0;
			else
				w = $urandom_range(0, 7);
			if (w > 0) begin
				res_stall <= 1'b1;
				repeat (w) @(posedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			taken++;
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed part: the empty basis, zero as a vector and as a rank, the
		// all-ones and top-bit vectors, a dependent insert, ranks at and just
		// past the size of the reachable set, and a rank with every bit set.
		directed.push_back(mk(OP_MAX, '0));
		directed.push_back(mk(OP_KTH, VAL_W'(1)));
		directed.push_back(mk(OP_CHECK, '0));
		directed.push_back(mk(OP_INSERT, '0));
		directed.push_back(mk(OP_KTH, VAL_W'(1)));
		directed.push_back(mk(OP_KTH, '0));
		directed.push_back(mk(OP_INSERT, {VAL_W{1'b1}}));
		directed.push_back(mk(OP_INSERT, VAL_W'(1) << (VAL_W - 1)));
		directed.push_back(mk(OP_INSERT, VAL_W'(1)));
		directed.push_back(mk(OP_INSERT, VAL_W'(5)));
		directed.push_back(mk(OP_CHECK, {VAL_W{1'b1}} >> 1));
		directed.push_back(mk(OP_CHECK, VAL_W'(2)));
		directed.push_back(mk(OP_INSERT, VAL_W'(1) << (VAL_W - 1)));
		directed.push_back(mk(OP_MAX, '0));
		directed.push_back(mk(OP_KTH, VAL_W'(2)));
		directed.push_back(mk(OP_KTH, VAL_W'(16)));
		directed.push_back(mk(OP_KTH, VAL_W'(17)));
		directed.push_back(mk(OP_KTH, {VAL_W{1'b1}}));
		directed.push_back(mk(OP_CHECK, {VAL_W{1'b1}}));
		directed.push_back(mk(OP_INSERT, VAL_W'(2)));
		directed.push_back(mk(OP_CHECK, VAL_W'(2)));
		directed.push_back(mk(OP_MAX, {VAL_W{1'b1}}));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i], 1'b0);
		drain();

		for (int n = 0; n < N_RAND; n++) begin
			// Once in the run the sender waits for the block to empty completely.
			if (n == PAUSE_AT)
				drain();
			send_item(next_random(n), n >= QUIET_FIRST && n < QUIET_LAST);
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("xor_linear_basis_test: done, clean");
		else
			$display("xor_linear_basis_test: done, errors");
		$finish;
	end

endmodule
